@@ rtl/bsc_pkg.sv @@
// Shared types, constants and coefficient unpacking for the barometer compensation core.
package bsc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_LOW  = 2'd0;
  localparam logic [1:0] CFG_IDX_MID  = 2'd1;
  localparam logic [1:0] CFG_IDX_HIGH = 2'd2;

  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_HIGH_W  = 40;

  // Input queue between the front and the back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic signed [31:0] TEMP_MAX = 32'sd8388607;
  localparam logic signed [31:0] TEMP_MIN = -32'sd8388608;

  // Accepted item as it waits in the queue
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
    logic        calib_invalid;
  } bsc_item_t;

  // Item after the temperature path
  typedef struct packed {
    logic signed [23:0] tq;
    logic [23:0]        u;
    logic               sat;
    logic               inv;
  } bsc_tag_t;

  // Calibration coefficients as stored by the sensor
  typedef struct packed {
    logic [15:0]        t1;
    logic [15:0]        t2;
    logic signed [7:0]  t3;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic [15:0]        p5;
    logic [15:0]        p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } bsc_coef_t;

  function automatic bsc_coef_t calib_coefs(input logic [CFG_DATA_W-1:0] lo,
                                            input logic [CFG_DATA_W-1:0] mid,
                                            input logic [CFG_HIGH_W-1:0] hi);
    logic [167:0] b;
    bsc_coef_t    c;
    b     = {hi, mid, lo};
    c.t1  = b[15:0];
    c.t2  = b[31:16];
    c.t3  = $signed(b[39:32]);
    c.p1  = $signed(b[55:40]);
    c.p2  = $signed(b[71:56]);
    c.p3  = $signed(b[79:72]);
    c.p4  = $signed(b[87:80]);
    c.p5  = b[103:88];
    c.p6  = b[119:104];
    c.p7  = $signed(b[127:120]);
    c.p8  = $signed(b[135:128]);
    c.p9  = $signed(b[151:136]);
    c.p10 = $signed(b[159:152]);
    c.p11 = $signed(b[167:160]);
    return c;
  endfunction

endpackage

@@ rtl/bsc_front.sv @@
// Front end: accepts items, tags calibration validity and queues them for the back end.
module bsc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [23:0]         raw_pressure_i,
  input  logic [23:0]         raw_temperature_i,
  input  logic                calib_zero_i,
  output logic                out_valid_o,
  output bsc_pkg::bsc_item_t  out_item_o
);
  import bsc_pkg::*;

  bsc_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                push, pop;
  bsc_item_t           new_item;

  assign busy        = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push        = start & ~busy;
  // the back end never stalls: drain one item every cycle
  assign pop         = (cnt_q != '0);
  assign out_valid_o = pop;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    new_item.raw_pressure    = raw_pressure_i;
    new_item.raw_temperature = raw_temperature_i;
    new_item.calib_invalid   = calib_zero_i;
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

@@ rtl/bsc_temp.sv @@
// Temperature polynomial: four pipeline stages from raw reading to clamped fixed point.
module bsc_temp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsc_pkg::bsc_coef_t coefs_i,
  input  logic               in_valid_i,
  input  bsc_pkg::bsc_item_t in_item_i,
  output logic               out_valid_o,
  output bsc_pkg::bsc_tag_t  out_tag_o
);
  import bsc_pkg::*;

  logic [3:1]          vld_q;
  bsc_item_t           item_q [1:3];

  logic signed [25:0]  d_q, d_d;
  logic signed [42:0]  dt2_q, dt2_d, dt2b_q;
  logic signed [49:0]  dd_q, dd_d;
  logic signed [57:0]  ddt3_q, ddt3_d;
  logic signed [63:0]  tn;
  logic signed [31:0]  tr;
  bsc_tag_t            tag_d, tag_q;
  logic                vld_out_q;

  always_comb begin
    d_d    = $signed({2'b00, in_item_i.raw_temperature}) - $signed({2'b00, coefs_i.t1, 8'h00});
    dt2_d  = 43'(d_q) * 43'($signed({1'b0, coefs_i.t2}));
    dd_d   = 50'(d_q) * 50'(d_q);
    ddt3_d = 58'(dd_q) * 58'(coefs_i.t3);
    // round half up to 2^-16 degree
    tn     = (64'(dt2b_q) <<< 18) + 64'(ddt3_q) + (64'sd1 <<< 31);
    tr     = tn[63:32];
    tag_d.u   = item_q[3].raw_pressure;
    tag_d.inv = item_q[3].calib_invalid;
    if (tr > TEMP_MAX) begin
      tag_d.tq  = TEMP_MAX[23:0];
      tag_d.sat = 1'b1;
    end else if (tr < TEMP_MIN) begin
      tag_d.tq  = TEMP_MIN[23:0];
      tag_d.sat = 1'b1;
    end else begin
      tag_d.tq  = tr[23:0];
      tag_d.sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[2:1], in_valid_i};
      vld_out_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    item_q[1] <= in_item_i;
    item_q[2] <= item_q[1];
    item_q[3] <= item_q[2];
    d_q       <= d_d;
    dt2_q     <= dt2_d;
    dd_q      <= dd_d;
    dt2b_q    <= dt2_q;
    ddt3_q    <= ddt3_d;
    tag_q     <= tag_d;
  end

  assign out_valid_o = vld_out_q;
  assign out_tag_o   = tag_q;

endmodule

@@ rtl/bsc_pres.sv @@
// Pressure polynomial: Horner evaluation in temperature, split products, rounding and clamping.
module bsc_pres (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsc_pkg::bsc_coef_t coefs_i,
  input  logic               in_valid_i,
  input  bsc_pkg::bsc_tag_t  in_tag_i,
  output logic               result_valid_o,
  output logic signed [23:0] temperature_fixed_o,
  output logic [23:0]        pressure_fixed_o,
  output logic               out_of_range_o,
  output logic               calib_invalid_o
);
  import bsc_pkg::*;

  logic [7:1]           vld_q;
  bsc_tag_t             tag_q [1:7];

  logic signed [24:0]   us0, us2;
  logic signed [48:0]   u2s;
  logic signed [17:0]   c1, c2;
  logic signed [16:0]   p5s, p6s;

  logic [47:0]          q1_u2_q, q1_u2_d;
  logic signed [32:0]   q1_x3_q, q1_x3_d;
  logic signed [31:0]   q1_p3u_q, q1_p3u_d;
  logic signed [41:0]   q1_b1_q, q1_b1_d, q1_b2_q, q1_b2_d;

  logic signed [56:0]   q2_y3_q, q2_y3_d;
  logic signed [53:0]   q2_x2_q, q2_x2_d;
  logic signed [56:0]   q2_u2p10_q, q2_u2p10_d, q2_u2p11_q, q2_u2p11_d;
  logic signed [64:0]   q2_u2p9_q, q2_u2p9_d;
  logic signed [41:0]   q2_b1_q, q2_b2_q;

  logic signed [57:0]   q3_z2_q, q3_z2_d;
  logic signed [83:0]   q3_x1_q, q3_x1_d;
  logic signed [53:0]   q3_r11l_q, q3_r11l_d, q3_r11h_q, q3_r11h_d;
  logic signed [109:0]  q3_x0a_q, q3_x0a_d;

  logic signed [53:0]   q4_y2l_q, q4_y2l_d, q4_y2h_q, q4_y2h_d;
  logic signed [109:0]  q4_x0_q, q4_x0_d;
  logic signed [83:0]   q4_x1_q;

  logic signed [83:0]   q5_z1_q, q5_z1_d;
  logic signed [109:0]  q5_x0_q;

  logic signed [52:0]   q6_y1a_q, q6_y1a_d, q6_y1b_q, q6_y1b_d, q6_y1c_q, q6_y1c_d;
  logic signed [109:0]  q6_x0_q;

  logic signed [109:0]  q7_s_q, q7_s_d;

  logic signed [109:0]  sr;
  logic                 res_vld_q;
  logic signed [23:0]   res_t_q, res_t_d;
  logic [23:0]          res_p_q, res_p_d;
  logic                 res_oor_q, res_oor_d, res_inv_q, res_inv_d;

  always_comb begin
    us0 = $signed({1'b0, in_tag_i.u});
    us2 = $signed({1'b0, tag_q[2].u});
    u2s = $signed({1'b0, q1_u2_q});
    c1  = 18'(coefs_i.p1) - 18'sd16384;
    c2  = 18'(coefs_i.p2) - 18'sd16384;
    p5s = $signed({1'b0, coefs_i.p5});
    p6s = $signed({1'b0, coefs_i.p6});

    // stage 1: products in the raw pressure
    q1_u2_d  = 48'(in_tag_i.u) * 48'(in_tag_i.u);
    q1_x3_d  = (33'(coefs_i.p8) <<< 22) + 33'(coefs_i.p4) * 33'(us0);
    q1_p3u_d = 32'(coefs_i.p3) * 32'(us0);
    q1_b1_d  = 42'(c1) * 42'(us0);
    q1_b2_d  = 42'(c2) * 42'(us0);

    // stage 2: innermost Horner step, squared-pressure products
    q2_y3_d    = 57'(q1_x3_q) * 57'(tag_q[1].tq);
    q2_x2_d    = (54'(coefs_i.p7) <<< 45) + (54'(q1_p3u_q) <<< 21);
    q2_u2p10_d = 57'(u2s) * 57'(coefs_i.p10);
    q2_u2p11_d = 57'(u2s) * 57'(coefs_i.p11);
    q2_u2p9_d  = 65'(u2s) * 65'(coefs_i.p9);

    // stage 3: collect the t^2 and t coefficients, cube term in halves
    q3_z2_d   = 58'(q2_x2_q) + 58'(q2_y3_q);
    q3_x1_d   = (84'(p6s) <<< 63) + (84'(q2_b2_q) <<< 40) + (84'(q2_u2p10_q) <<< 21);
    q3_r11l_d = 54'($signed({1'b0, q2_u2p11_q[27:0]})) * 54'(us2);
    q3_r11h_d = 54'($signed(q2_u2p11_q[56:28])) * 54'(us2);
    q3_x0a_d  = (110'(p5s) <<< 88) + (110'(q2_b1_q) <<< 65) + (110'(q2_u2p9_q) <<< 37);

    // stage 4: second Horner step in two halves
    q4_y2l_d = 54'($signed({1'b0, q3_z2_q[28:0]})) * 54'(tag_q[3].tq);
    q4_y2h_d = 54'($signed(q3_z2_q[57:29])) * 54'(tag_q[3].tq);
    q4_x0_d  = q3_x0a_q + (110'(q3_r11h_q) <<< 48) + (110'(q3_r11l_q) <<< 20);

    // stage 5
    q5_z1_d = q4_x1_q + (84'(q4_y2h_q) <<< 29) + 84'(q4_y2l_q);

    // stage 6: last Horner step in three slices
    q6_y1a_d = 53'($signed({1'b0, q5_z1_q[27:0]})) * 53'(tag_q[5].tq);
    q6_y1b_d = 53'($signed({1'b0, q5_z1_q[55:28]})) * 53'(tag_q[5].tq);
    q6_y1c_d = 53'($signed(q5_z1_q[83:56])) * 53'(tag_q[5].tq);

    // stage 7
    q7_s_d = q6_x0_q + (110'(q6_y1c_q) <<< 56) + (110'(q6_y1b_q) <<< 28) + 110'(q6_y1a_q);

    // round to 2^-6 Pa, clamp at both ends
    sr        = q7_s_q + (110'sd1 <<< 78);
    res_t_d   = tag_q[7].tq;
    res_inv_d = 1'b0;
    if (sr[109]) begin
      res_p_d   = '0;
      res_oor_d = 1'b1;
    end else if (|sr[108:103]) begin
      res_p_d   = '1;
      res_oor_d = 1'b1;
    end else begin
      res_p_d   = sr[102:79];
      res_oor_d = tag_q[7].sat;
    end
    if (tag_q[7].inv) begin
      res_t_d   = '0;
      res_p_d   = '0;
      res_oor_d = 1'b0;
      res_inv_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[6:1], in_valid_i};
      res_vld_q <= vld_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[1] <= in_tag_i;
    for (int i = 2; i <= 7; i++) begin
      tag_q[i] <= tag_q[i-1];
    end
    q1_u2_q    <= q1_u2_d;
    q1_x3_q    <= q1_x3_d;
    q1_p3u_q   <= q1_p3u_d;
    q1_b1_q    <= q1_b1_d;
    q1_b2_q    <= q1_b2_d;
    q2_y3_q    <= q2_y3_d;
    q2_x2_q    <= q2_x2_d;
    q2_u2p10_q <= q2_u2p10_d;
    q2_u2p11_q <= q2_u2p11_d;
    q2_u2p9_q  <= q2_u2p9_d;
    q2_b1_q    <= q1_b1_q;
    q2_b2_q    <= q1_b2_q;
    q3_z2_q    <= q3_z2_d;
    q3_x1_q    <= q3_x1_d;
    q3_r11l_q  <= q3_r11l_d;
    q3_r11h_q  <= q3_r11h_d;
    q3_x0a_q   <= q3_x0a_d;
    q4_y2l_q   <= q4_y2l_d;
    q4_y2h_q   <= q4_y2h_d;
    q4_x0_q    <= q4_x0_d;
    q4_x1_q    <= q3_x1_q;
    q5_z1_q    <= q5_z1_d;
    q5_x0_q    <= q4_x0_q;
    q6_y1a_q   <= q6_y1a_d;
    q6_y1b_q   <= q6_y1b_d;
    q6_y1c_q   <= q6_y1c_d;
    q6_x0_q    <= q5_x0_q;
    q7_s_q     <= q7_s_d;
    res_t_q    <= res_t_d;
    res_p_q    <= res_p_d;
    res_oor_q  <= res_oor_d;
    res_inv_q  <= res_inv_d;
  end

  assign result_valid_o      = res_vld_q;
  assign temperature_fixed_o = res_t_q;
  assign pressure_fixed_o    = res_p_q;
  assign out_of_range_o      = res_oor_q;
  assign calib_invalid_o     = res_inv_q;

endmodule

@@ rtl/baro_sensor_compensation_core.sv @@
// Top level of the barometer compensation core: calibration registers, front end and pipelines.
//
//  channel   | signals                                          | handshake
//  ----------+--------------------------------------------------+-------------------------------
//  item in   | raw_pressure_i, raw_temperature_i                | taken when start & !busy
//  result    | temperature_fixed_o, pressure_fixed_o,           | result_valid_o, one cycle,
//            | out_of_range_o, calib_invalid_o                  | receiver cannot hold it off
//  config    | cfg_idx_i, cfg_wdata_i                           | written when cfg_we_i
//
//  One item per cycle sustained; each result strobe follows its item through these registers:
//  the queue entry is read in the cycle after the accepting edge, then four temperature
//  stages, seven pressure stages and the output register.
//  Reset clears the calibration registers (flagging an invalid calibration), the queue and
//  all valid bits. The pipelines never stall, so busy stays low under continuous start.
module baro_sensor_compensation_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item in
  input  logic                start,
  output logic                busy,
  input  logic [23:0]         raw_pressure_i,
  input  logic [23:0]         raw_temperature_i,
  // result
  output logic                result_valid_o,
  output logic signed [23:0]  temperature_fixed_o,
  output logic [23:0]         pressure_fixed_o,
  output logic                out_of_range_o,
  output logic                calib_invalid_o,
  // configuration
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_wdata_i
);
  import bsc_pkg::*;

  logic [CFG_DATA_W-1:0] cal_lo_q, cal_lo_d;
  logic [CFG_DATA_W-1:0] cal_mid_q, cal_mid_d;
  logic [CFG_HIGH_W-1:0] cal_hi_q, cal_hi_d;
  bsc_coef_t             coefs;
  logic                  calib_zero;
  logic                  q_valid;
  bsc_item_t             q_item;
  logic                  t_valid;
  bsc_tag_t              t_tag;

  // Hold calibration words; drop writes to unknown indexes and the high bits of the last word
  always_comb begin
    cal_lo_d  = cal_lo_q;
    cal_mid_d = cal_mid_q;
    cal_hi_d  = cal_hi_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_LOW:  cal_lo_d  = cfg_wdata_i;
        CFG_IDX_MID:  cal_mid_d = cfg_wdata_i;
        CFG_IDX_HIGH: cal_hi_d  = cfg_wdata_i[CFG_HIGH_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_lo_q  <= '0;
      cal_mid_q <= '0;
      cal_hi_q  <= '0;
    end else begin
      cal_lo_q  <= cal_lo_d;
      cal_mid_q <= cal_mid_d;
      cal_hi_q  <= cal_hi_d;
    end
  end

  // User must change calibration only while idle (not enforced), so coefs are static per item
  assign coefs      = calib_coefs(cal_lo_q, cal_mid_q, cal_hi_q);
  assign calib_zero = (cal_lo_q == '0) && (cal_mid_q == '0) && (cal_hi_q == '0);

  bsc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .calib_zero_i      (calib_zero),
    .out_valid_o       (q_valid),
    .out_item_o        (q_item)
  );

  bsc_temp u_temp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coefs_i     (coefs),
    .in_valid_i  (q_valid),
    .in_item_i   (q_item),
    .out_valid_o (t_valid),
    .out_tag_o   (t_tag)
  );

  bsc_pres u_pres (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .coefs_i             (coefs),
    .in_valid_i          (t_valid),
    .in_tag_i            (t_tag),
    .result_valid_o      (result_valid_o),
    .temperature_fixed_o (temperature_fixed_o),
    .pressure_fixed_o    (pressure_fixed_o),
    .out_of_range_o      (out_of_range_o),
    .calib_invalid_o     (calib_invalid_o)
  );

endmodule
